[src/aeg_pkg.sv]
// Shared types, constants and coefficient tables for the anisotropy evaluator.
// No dependencies; the core takes names from here by scope.
`default_nettype none
package aeg_pkg;

  localparam int SET_SIZE = 21;
  localparam int K2_COUNT = 6;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic [3:0]         site;
    logic [4:0]         coef_index;
    logic signed [31:0] coef_value;
    logic signed [15:0] spin_x;
    logic signed [15:0] spin_y;
    logic signed [15:0] spin_z;
  } in_t;

  typedef struct packed {
    logic signed [47:0] energy;
    logic signed [47:0] grad_x;
    logic signed [47:0] grad_y;
    logic signed [47:0] grad_z;
    logic               saturated;
  } out_t;

  // One gradient lane of a component: count of the index and the indices left over.
  typedef struct packed {
    logic [2:0] cnt;
    logic [1:0] r0;
    logic [1:0] r1;
    logic [1:0] r2;
  } lane_t;

  // Tensor indices of a component, first index in the top two bits.
  function automatic logic [7:0] comp_ix(input logic [4:0] c);
    logic [7:0] ix;
    case (c)
      5'd0:    ix = {2'd0, 2'd0, 2'd0, 2'd0};
      5'd1:    ix = {2'd0, 2'd1, 2'd0, 2'd0};
      5'd2:    ix = {2'd0, 2'd2, 2'd0, 2'd0};
      5'd3:    ix = {2'd1, 2'd1, 2'd0, 2'd0};
      5'd4:    ix = {2'd1, 2'd2, 2'd0, 2'd0};
      5'd5:    ix = {2'd2, 2'd2, 2'd0, 2'd0};
      5'd6:    ix = {2'd0, 2'd0, 2'd0, 2'd0};
      5'd7:    ix = {2'd0, 2'd0, 2'd0, 2'd1};
      5'd8:    ix = {2'd0, 2'd0, 2'd0, 2'd2};
      5'd9:    ix = {2'd0, 2'd0, 2'd1, 2'd1};
      5'd10:   ix = {2'd0, 2'd0, 2'd1, 2'd2};
      5'd11:   ix = {2'd0, 2'd0, 2'd2, 2'd2};
      5'd12:   ix = {2'd0, 2'd1, 2'd1, 2'd1};
      5'd13:   ix = {2'd0, 2'd1, 2'd1, 2'd2};
      5'd14:   ix = {2'd0, 2'd1, 2'd2, 2'd2};
      5'd15:   ix = {2'd0, 2'd2, 2'd2, 2'd2};
      5'd16:   ix = {2'd1, 2'd1, 2'd1, 2'd1};
      5'd17:   ix = {2'd1, 2'd1, 2'd1, 2'd2};
      5'd18:   ix = {2'd1, 2'd1, 2'd2, 2'd2};
      5'd19:   ix = {2'd1, 2'd2, 2'd2, 2'd2};
      5'd20:   ix = {2'd2, 2'd2, 2'd2, 2'd2};
      default: ix = '0;
    endcase
    return ix;
  endfunction

  // Number of index permutations that a stored component stands for.
  function automatic logic [3:0] comp_mult(input logic [4:0] c);
    logic [3:0] m;
    case (c)
      5'd1, 5'd2, 5'd4:                   m = 4'd2;
      5'd7, 5'd8, 5'd12, 5'd15, 5'd17, 5'd19: m = 4'd4;
      5'd9, 5'd11, 5'd18:                 m = 4'd6;
      5'd10, 5'd13, 5'd14:                m = 4'd12;
      5'd0, 5'd3, 5'd5, 5'd6, 5'd16, 5'd20: m = 4'd1;
      default:                            m = 4'd0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[src/anisotropy_energy_gradient_eval_core.sv]
// Quartic anisotropy energy and gradient evaluator, top level.
// Depends on aeg_pkg and aeg_ram (coefficient table).
//
//  channel  | handshake                 | word
//  ---------+---------------------------+------------------------------
//  command  | start / busy              | item   (aeg_pkg::in_t)
//  result   | done (one-cycle strobe)   | result (aeg_pkg::out_t)
//  config   | cfg_valid / cfg_ready     | cfg_data (global_mode)
//
// A load writes the table and leaves busy low. An evaluate reads the 21
// coefficients of its set one per cycle from the table's single read port,
// then drains the multiply pipeline in the DRAIN state and raises done from
// the FIN state. After reset a clearing pass writes zero to all
// NUM_SITES*21 table words, one per cycle, with busy high; cfg writes are
// taken throughout. The result cannot be stalled.
`default_nettype none
module anisotropy_energy_gradient_eval_core #(
  parameter int NUM_SITES = 16
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire aeg_pkg::in_t  item,
  output logic               busy,
  output logic               done,
  output aeg_pkg::out_t      result,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_data
);

  localparam int DEPTH = NUM_SITES * aeg_pkg::SET_SIZE;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_RUN, ST_DRAIN, ST_FIN} state_t;

  state_t             state;
  logic [AW-1:0]      clr_addr;
  logic               global_mode;
  logic [4:0]         c;
  logic [AW-1:0]      base;
  logic signed [15:0] spin [3];

  logic               accept;
  logic               ld_ok;
  logic               site_ok;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;
  logic [AW-1:0]      raddr;
  logic [31:0]        rdata;

  // Pipeline registers.
  logic               v1, v2, v3;
  logic [4:0]         s1_c, s2_c;
  logic               s1_deg4;
  logic signed [31:0] s1_ea, s1_eb;
  logic signed [31:0] s1_ga [3];
  logic signed [15:0] s1_gc [3];
  logic [2:0]         s1_cnt [3];
  logic [2:0]         s2_cnt [3];
  logic signed [31:0] s2_k;
  logic signed [31:0] s2_es;
  logic signed [31:0] s2_gs [3];
  logic signed [43:0] s3_te;
  logic signed [43:0] s3_tg [3];
  logic [3:0]         s3_we;
  logic [6:0]         s3_wg [3];
  logic signed [55:0] acc_e;
  logic signed [55:0] acc_g [3];

  logic [7:0]         ix;
  logic               deg4;
  aeg_pkg::lane_t     lane [3];

  function automatic aeg_pkg::lane_t lane_of(input logic [7:0] cix, input logic d4,
                                             input logic [1:0] p);
    aeg_pkg::lane_t   l;
    logic             found;
    logic [1:0]       idx;
    logic [2:0][1:0]  rem;
    int               n;
    l     = '0;
    found = 1'b0;
    rem   = '0;
    n     = 0;
    for (int q = 0; q < 4; q++) begin
      if (q < 2 || d4) begin
        idx = cix[(3 - q) * 2 +: 2];
        if (idx == p) begin
          l.cnt = l.cnt + 3'd1;
        end
        if (idx == p && !found) begin
          found = 1'b1;
        end else if (n < 3) begin
          rem[n] = idx;
          n      = n + 1;
        end
      end
    end
    l.r0 = rem[0];
    l.r1 = rem[1];
    l.r2 = rem[2];
    return l;
  endfunction

  // Negate, round half up from Q.26 to Q32.16 and clip to 48 bits.
  function automatic logic [48:0] finish(input logic signed [55:0] a);
    logic signed [59:0] t;
    logic signed [49:0] r;
    logic               sat;
    logic signed [47:0] v;
    t = -60'(a) + 60'sd512;
    r = t[59:10];
    sat = 1'b0;
    v   = r[47:0];
    if (r > 50'sh0_7FFF_FFFF_FFFF) begin
      sat = 1'b1;
      v   = 48'sh7FFF_FFFF_FFFF;
    end else if (r < -50'sh0_8000_0000_0000) begin
      sat = 1'b1;
      v   = -48'sh8000_0000_0000;
    end
    return {sat, v};
  endfunction

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign site_ok = (32'(item.site) < NUM_SITES);
  assign ld_ok   = accept && (item.cmd == aeg_pkg::CMD_LOAD)
                   && (32'(item.coef_index) < aeg_pkg::SET_SIZE) && site_ok
                   && !(global_mode && (item.site != 4'd0));

  assign we    = (state == ST_CLEAR) || ld_ok;
  assign waddr = (state == ST_CLEAR) ? clr_addr
               : AW'(32'(item.site) * aeg_pkg::SET_SIZE + 32'(item.coef_index));
  assign wdata = (state == ST_CLEAR) ? 32'd0 : item.coef_value;
  assign raddr = base + AW'(c);

  aeg_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Control sequencer and result register.
  always_ff @(posedge clk) begin
    logic [48:0] fe, fx, fy, fz;
    fe = finish(acc_e);
    fx = finish(acc_g[0]);
    fy = finish(acc_g[1]);
    fz = finish(acc_g[2]);
    if (rst) begin
      state       <= ST_CLEAR;
      clr_addr    <= '0;
      global_mode <= 1'b0;
      done        <= 1'b0;
      c           <= '0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        global_mode <= cfg_data;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept && item.cmd == aeg_pkg::CMD_EVAL) begin
            state   <= ST_RUN;
            c       <= '0;
            base    <= (global_mode || !site_ok) ? '0
                     : AW'(32'(item.site) * aeg_pkg::SET_SIZE);
            spin[0] <= item.spin_x;
            spin[1] <= item.spin_y;
            spin[2] <= item.spin_z;
          end
        end
        ST_RUN: begin
          c <= c + 5'd1;
          if (c == 5'(aeg_pkg::SET_SIZE - 1)) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!v1 && !v2 && !v3) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          result.energy    <= fe[47:0];
          result.grad_x    <= fx[47:0];
          result.grad_y    <= fy[47:0];
          result.grad_z    <= fz[47:0];
          result.saturated <= fe[48] | fx[48] | fy[48] | fz[48];
          done             <= 1'b1;
          state            <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign ix   = aeg_pkg::comp_ix(c);
  assign deg4 = (c >= 5'(aeg_pkg::K2_COUNT));

  always_comb begin
    for (int p = 0; p < 3; p++) begin
      lane[p] = lane_of(ix, deg4, 2'(p));
    end
  end

  // Stage 1 forms spin pairs, stage 2 the spin monomials in Q.30, stage 3
  // the coefficient products in Q.26, stage 4 weights and accumulates.
  always_ff @(posedge clk) begin
    logic signed [63:0] pe;
    logic signed [64:0] re;
    logic signed [47:0] pg;
    logic signed [48:0] rg;
    logic signed [63:0] pk;
    logic signed [64:0] rk;
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= (state == ST_RUN);
      v2 <= v1;
      v3 <= v2;
    end

    s1_c    <= c;
    s1_deg4 <= deg4;
    s1_ea   <= 32'(spin[ix[7:6]]) * 32'(spin[ix[5:4]]);
    s1_eb   <= 32'(spin[ix[3:2]]) * 32'(spin[ix[1:0]]);
    for (int p = 0; p < 3; p++) begin
      s1_cnt[p] <= lane[p].cnt;
      s1_ga[p]  <= deg4 ? 32'(spin[lane[p].r0]) * 32'(spin[lane[p].r1])
                        : 32'(spin[lane[p].r0]) <<< 15;
      s1_gc[p]  <= spin[lane[p].r2];
    end

    s2_c <= s1_c;
    s2_k <= $signed(rdata);
    pe = 64'(s1_ea) * 64'(s1_eb);
    re = 65'(pe) + (65'sd1 <<< 29);
    s2_es <= s1_deg4 ? re[61:30] : s1_ea;
    for (int p = 0; p < 3; p++) begin
      s2_cnt[p] <= s1_cnt[p];
      pg = 48'(s1_ga[p]) * 48'(s1_gc[p]);
      rg = 49'(pg) + (49'sd1 <<< 14);
      s2_gs[p] <= s1_deg4 ? rg[46:15] : s1_ga[p];
    end

    pk = 64'(s2_k) * 64'(s2_es);
    rk = 65'(pk) + (65'sd1 <<< 19);
    s3_te <= rk[63:20];
    s3_we <= aeg_pkg::comp_mult(s2_c);
    for (int p = 0; p < 3; p++) begin
      pk = 64'(s2_k) * 64'(s2_gs[p]);
      rk = 65'(pk) + (65'sd1 <<< 19);
      s3_tg[p] <= rk[63:20];
      s3_wg[p] <= 7'(aeg_pkg::comp_mult(s2_c)) * 7'(s2_cnt[p]);
    end

    if (accept && item.cmd == aeg_pkg::CMD_EVAL) begin
      acc_e <= '0;
      for (int p = 0; p < 3; p++) begin
        acc_g[p] <= '0;
      end
    end else if (v3) begin
      acc_e <= acc_e + 56'(s3_te) * 56'($signed({1'b0, s3_we}));
      for (int p = 0; p < 3; p++) begin
        acc_g[p] <= acc_g[p] + 56'(s3_tg[p]) * 56'($signed({1'b0, s3_wg[p]}));
      end
    end
  end

  a_done_after_fin: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_FIN)
    else $error("result strobe without a finished evaluation");

  a_eval_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == aeg_pkg::CMD_EVAL) |=> busy)
    else $error("evaluate accepted but block not busy");

  a_no_write_in_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN || state == ST_DRAIN) |-> !we)
    else $error("table written during an evaluation");

endmodule
`default_nettype wire

[src/aeg_ram.sv]
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none
module aeg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 336
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
